/* hdl/rv32_exu_pkg.sv */
// ----------------------------------------------------------------------------
// rv32_exu_pkg
// shared types and constants of the rv32im execute unit
// ----------------------------------------------------------------------------
package rv32_exu_pkg;

	localparam int unsigned REG_COUNT_DEFAULT = 32;
	localparam int unsigned XLEN = 32;

	typedef enum logic [5:0] {
		OP_ADD = 6'd0, OP_SUB = 6'd1, OP_SLL = 6'd2, OP_SLT = 6'd3, OP_SLTU = 6'd4,
		OP_XOR = 6'd5, OP_SRL = 6'd6, OP_SRA = 6'd7, OP_OR = 6'd8, OP_AND = 6'd9,
		OP_ADDI = 6'd10, OP_SLTI = 6'd11, OP_SLTIU = 6'd12, OP_XORI = 6'd13,
		OP_ORI = 6'd14, OP_ANDI = 6'd15, OP_SLLI = 6'd16, OP_SRLI = 6'd17,
		OP_SRAI = 6'd18, OP_JAL = 6'd19, OP_JALR = 6'd20, OP_BEQ = 6'd21,
		OP_BNE = 6'd22, OP_BLT = 6'd23, OP_BGE = 6'd24, OP_BLTU = 6'd25,
		OP_BGEU = 6'd26, OP_LUI = 6'd27, OP_AUIPC = 6'd28, OP_MUL = 6'd29,
		OP_MULH = 6'd30, OP_MULHSU = 6'd31, OP_MULHU = 6'd32, OP_DIV = 6'd33,
		OP_DIVU = 6'd34, OP_REM = 6'd35, OP_REMU = 6'd36
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item, read register file
		logic exec;      // compute alu result / start long op
		logic div_step;  // one divider iteration
		logic mul_fin;   // select high or low half of the registered product
		logic finish;    // write back and present result
	} exu_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_div;
		logic is_mul;
		logic div_last;
	} exu_sts_t;

endpackage

/* hdl/rv32im_execute_unit.sv */
// ----------------------------------------------------------------------------
// rv32im_execute_unit
// executes one decoded rv32im instruction per item against its own register file
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one decoded instruction per item, m_axis one result per item
//   results leave in the order items arrive, exactly one per item
//   from accept, an alu, branch or jump item passes the exec and finish states,
//   multiplies add one registered 33x33 product, and divides and
//   remainders a radix-2 divider state with one quotient bit a cycle
//   the controller holds one item at a time, so the next item is taken
//   only once the last one has reached its finish; the result register
//   frees the input side: the next item is taken while a result still
//   waits, and only its write-back waits for the stall to end
//   reset clears the controller and the register valid bits, so every
//   register reads zero after reset without a clearing pass
//   register zero reads zero; numbers at or above REGISTER_COUNT read zero
// ----------------------------------------------------------------------------
module rv32im_execute_unit #(
	parameter int unsigned REGISTER_COUNT = rv32_exu_pkg::REG_COUNT_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action[5:0], dest_reg[10:6], src1_reg[15:11], src2_reg[20:16],
	// immediate[52:21], current_pc[84:53], zero fill
	input  logic [87:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// write_data[31:0], writes_reg[32], next_pc[64:33], zero fill
	output logic [71:0]  m_axis_tdata
);

	rv32_exu_pkg::exu_cmd_t cmd;
	rv32_exu_pkg::exu_sts_t sts;
	logic [31:0] write_data, next_pc;
	logic        writes_reg;

	rv32_exu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rv32_exu_datapath #(.REGISTER_COUNT(REGISTER_COUNT)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (s_axis_tdata[5:0]),
		.dest_reg   (s_axis_tdata[10:6]),
		.src1_reg   (s_axis_tdata[15:11]),
		.src2_reg   (s_axis_tdata[20:16]),
		.immediate  (s_axis_tdata[52:21]),
		.current_pc (s_axis_tdata[84:53]),
		.write_data (write_data),
		.writes_reg (writes_reg),
		.next_pc    (next_pc)
	);

	assign m_axis_tdata = {7'd0, next_pc, writes_reg, write_data};

endmodule

/* hdl/rv32_exu_datapath.sv */
// ----------------------------------------------------------------------------
// rv32_exu_datapath
// register file, alu, multiplier and radix-2 divider
// ----------------------------------------------------------------------------
module rv32_exu_datapath #(
	parameter int unsigned REGISTER_COUNT = rv32_exu_pkg::REG_COUNT_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rv32_exu_pkg::exu_cmd_t cmd,
	output rv32_exu_pkg::exu_sts_t sts,
	input  logic [5:0]             action,
	input  logic [4:0]             dest_reg,
	input  logic [4:0]             src1_reg,
	input  logic [4:0]             src2_reg,
	input  logic [31:0]            immediate,
	input  logic [31:0]            current_pc,
	output logic [31:0]            write_data,
	output logic                   writes_reg,
	output logic [31:0]            next_pc
);

	logic [31:0] rf_q [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] rf_vld_q;

	logic [5:0]  op_q;
	logic [4:0]  rd_q;
	logic [31:0] a_q, b_q, imm_q, pc_q;

	logic [31:0] val_q;
	logic        wr_q;
	logic [31:0] npc_q;

	// divider and multiplier state
	logic [31:0] dq_q, dr_q, dd_q;
	logic [4:0]  dcnt_q;
	logic        neg_q, ovf_q, zero_q;
	logic [31:0] mula_q, mulb_q;
	logic        mhi_q;

	function automatic logic [31:0] rd_rf(input logic [4:0] idx,
		input logic [31:0] data, input logic vld);
		logic ok;
		ok = (idx != 5'd0) && ({27'd0, idx} < REGISTER_COUNT) && vld;
		return ok ? data : 32'd0;
	endfunction

	logic [31:0] rs1, rs2;
	always_comb begin
		rs1 = 32'd0;
		rs2 = 32'd0;
		for (int i = 0; i < REGISTER_COUNT; i++) begin
			if (src1_reg == 5'(i)) rs1 = rd_rf(src1_reg, rf_q[i], rf_vld_q[i]);
			if (src2_reg == 5'(i)) rs2 = rd_rf(src2_reg, rf_q[i], rf_vld_q[i]);
		end
	end

	logic        is_mul, is_div, sgn_op;
	logic [31:0] alu;
	logic        alu_wr, taken;
	logic [31:0] seq, opb;
	logic [4:0]  sh;
	always_comb begin
		is_mul = (op_q >= rv32_exu_pkg::OP_MUL) && (op_q <= rv32_exu_pkg::OP_MULHU);
		is_div = (op_q >= rv32_exu_pkg::OP_DIV) && (op_q <= rv32_exu_pkg::OP_REMU);
		sgn_op = (op_q == rv32_exu_pkg::OP_DIV) || (op_q == rv32_exu_pkg::OP_REM);
		seq = pc_q + 32'd4;
		opb = (op_q >= rv32_exu_pkg::OP_ADDI) ? imm_q : b_q;
		sh = opb[4:0];
		alu = 32'd0;
		alu_wr = 1'b1;
		taken = 1'b0;
		unique case (op_q)
			rv32_exu_pkg::OP_ADD, rv32_exu_pkg::OP_ADDI: alu = a_q + opb;
			rv32_exu_pkg::OP_SUB: alu = a_q - b_q;
			rv32_exu_pkg::OP_SLL, rv32_exu_pkg::OP_SLLI: alu = a_q << sh;
			rv32_exu_pkg::OP_SLT, rv32_exu_pkg::OP_SLTI:
				alu = {31'd0, $signed(a_q) < $signed(opb)};
			rv32_exu_pkg::OP_SLTU, rv32_exu_pkg::OP_SLTIU: alu = {31'd0, a_q < opb};
			rv32_exu_pkg::OP_XOR, rv32_exu_pkg::OP_XORI: alu = a_q ^ opb;
			rv32_exu_pkg::OP_SRL, rv32_exu_pkg::OP_SRLI: alu = a_q >> sh;
			rv32_exu_pkg::OP_SRA, rv32_exu_pkg::OP_SRAI: alu = 32'($signed(a_q) >>> sh);
			rv32_exu_pkg::OP_OR, rv32_exu_pkg::OP_ORI: alu = a_q | opb;
			rv32_exu_pkg::OP_AND, rv32_exu_pkg::OP_ANDI: alu = a_q & opb;
			rv32_exu_pkg::OP_JAL, rv32_exu_pkg::OP_JALR: alu = seq;
			rv32_exu_pkg::OP_BEQ: begin alu_wr = 1'b0; taken = a_q == b_q; end
			rv32_exu_pkg::OP_BNE: begin alu_wr = 1'b0; taken = a_q != b_q; end
			rv32_exu_pkg::OP_BLT: begin alu_wr = 1'b0; taken = $signed(a_q) < $signed(b_q); end
			rv32_exu_pkg::OP_BGE: begin
				alu_wr = 1'b0; taken = $signed(a_q) >= $signed(b_q);
			end
			rv32_exu_pkg::OP_BLTU: begin alu_wr = 1'b0; taken = a_q < b_q; end
			rv32_exu_pkg::OP_BGEU: begin alu_wr = 1'b0; taken = a_q >= b_q; end
			rv32_exu_pkg::OP_LUI: alu = imm_q;
			rv32_exu_pkg::OP_AUIPC: alu = pc_q + imm_q;
			rv32_exu_pkg::OP_MUL, rv32_exu_pkg::OP_MULH, rv32_exu_pkg::OP_MULHSU,
			rv32_exu_pkg::OP_MULHU, rv32_exu_pkg::OP_DIV, rv32_exu_pkg::OP_DIVU,
			rv32_exu_pkg::OP_REM, rv32_exu_pkg::OP_REMU: alu = 32'd0;
			default: alu_wr = 1'b0;
		endcase
	end

	logic [31:0] npc_c;
	always_comb begin
		if (op_q == rv32_exu_pkg::OP_JAL || taken) npc_c = pc_q + imm_q;
		else if (op_q == rv32_exu_pkg::OP_JALR) npc_c = (a_q + imm_q) & ~32'd1;
		else npc_c = seq;
	end

	// signed 33x33 product, one multiplier
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	always_comb begin
		ma = (op_q == rv32_exu_pkg::OP_MULH || op_q == rv32_exu_pkg::OP_MULHSU)
			? {a_q[31], a_q} : {1'b0, a_q};
		mb = (op_q == rv32_exu_pkg::OP_MULH) ? {b_q[31], b_q} : {1'b0, b_q};
		prod = ma * mb;
	end

	// restoring divider: one quotient bit a step on magnitudes
	logic [32:0] trial;
	logic [31:0] rem_sh;
	always_comb begin
		rem_sh = {dr_q[30:0], dq_q[31]};
		trial = {1'b0, rem_sh} - {1'b0, dd_q};
	end

	logic [31:0] div_res;
	always_comb begin
		logic [31:0] q, r;
		q = neg_q ? 32'd0 - dq_q : dq_q;
		r = (sgn_op && a_q[31]) ? 32'd0 - dr_q : dr_q;
		if (zero_q) begin
			q = 32'hffffffff;
			r = a_q;
		end else if (ovf_q) begin
			q = 32'h80000000;
			r = 32'd0;
		end
		div_res = (op_q == rv32_exu_pkg::OP_DIV || op_q == rv32_exu_pkg::OP_DIVU) ? q : r;
	end

	always_comb begin
		sts.is_div = is_div;
		sts.is_mul = is_mul;
		sts.div_last = (dcnt_q == 5'd31);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= action;
			rd_q  <= dest_reg;
			a_q   <= rs1;
			b_q   <= rs2;
			imm_q <= immediate;
			pc_q  <= current_pc;
		end
		if (cmd.exec) begin
			val_q <= alu;
			wr_q  <= alu_wr;
			npc_q <= npc_c;
			dq_q  <= (sgn_op && a_q[31]) ? 32'd0 - a_q : a_q;
			dd_q  <= (sgn_op && b_q[31]) ? 32'd0 - b_q : b_q;
			dr_q  <= 32'd0;
			dcnt_q <= 5'd0;
			neg_q <= sgn_op && (a_q[31] ^ b_q[31]);
			zero_q <= (b_q == 32'd0);
			ovf_q <= sgn_op && (a_q == 32'h80000000) && (b_q == 32'hffffffff);
			mhi_q <= (op_q != rv32_exu_pkg::OP_MUL);
			mula_q <= prod[31:0];
			mulb_q <= prod[63:32];
		end
		if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 5'd1;
			if (!trial[32]) begin
				dr_q <= trial[31:0];
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= rem_sh;
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
		if (cmd.mul_fin) val_q <= mhi_q ? mulb_q : mula_q;
	end

	logic [31:0] fin_val;
	assign fin_val = is_div ? div_res : val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (cmd.finish && wr_q && rd_q != 5'd0
			&& {27'd0, rd_q} < REGISTER_COUNT) begin
			rf_vld_q[rd_q[$clog2(REGISTER_COUNT)-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			for (int i = 1; i < REGISTER_COUNT; i++)
				if (wr_q && rd_q == 5'(i)) rf_q[i] <= fin_val;
			write_data <= wr_q ? fin_val : 32'd0;
			writes_reg <= wr_q;
			next_pc    <= npc_q;
		end
	end

endmodule

/* hdl/rv32_exu_ctrl.sv */
// ----------------------------------------------------------------------------
// rv32_exu_ctrl
// sequencing of one item and the output handshake
// ----------------------------------------------------------------------------
module rv32_exu_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output rv32_exu_pkg::exu_cmd_t cmd,
	input  rv32_exu_pkg::exu_sts_t sts
);

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_FIN} state_t;
	state_t state_q;
	logic   full_q;

	// a new item is taken while the previous result waits; only its finish waits for it
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = full_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.exec = (state_q == S_EXEC);
		cmd.div_step = (state_q == S_DIV);
		cmd.mul_fin = (state_q == S_MUL);
		cmd.finish = (state_q == S_FIN) && (!full_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			full_q  <= 1'b0;
		end else begin
			if (cmd.finish) full_q <= 1'b1;
			else if (out_ready) full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (sts.is_div) state_q <= S_DIV;
					else if (sts.is_mul) state_q <= S_MUL;
					else state_q <= S_FIN;
				end
				S_MUL: state_q <= S_FIN;
				S_DIV: if (sts.div_last) state_q <= S_FIN;
				S_FIN: if (!full_q || out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
